// ----- rtl/ptfl_pkg.sv -----
// Shared types and constants for the page table with FIFO/LRU replacement.
package ptfl_pkg;

    localparam int NumPagesDef  = 16;
    localparam int NumFramesDef = 8;

    localparam int PageW  = 4;
    localparam int FrameW = 3;
    localparam int TimeW  = 32;
    localparam int CountW = 32;

    localparam logic ModeFifo = 1'b0;
    localparam logic ModeLru  = 1'b1;

    typedef struct packed {
        logic [PageW-1:0] page;
        logic             wr_access;
        logic [TimeW-1:0] timestamp;
    } t_in_word;

    typedef struct packed {
        logic              hit;
        logic [FrameW-1:0] frame;
        logic              evicted;
        logic [PageW-1:0]  victim_page;
        logic              write_back;
        logic [CountW-1:0] hit_total;
        logic [CountW-1:0] miss_total;
    } t_out_word;

endpackage

// ----- rtl/ptfl_time_mem.sv -----
// Per-page timestamp memory: one write port, one registered read port.
module ptfl_time_mem #(
    parameter int NumPages = ptfl_pkg::NumPagesDef
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(NumPages)-1:0] i_waddr,
    input  logic [ptfl_pkg::TimeW-1:0]  i_wdata,
    input  logic [$clog2(NumPages)-1:0] i_raddr,
    output logic [ptfl_pkg::TimeW-1:0]  o_rdata
);

    logic [ptfl_pkg::TimeW-1:0] r_mem [NumPages];
    logic [ptfl_pkg::TimeW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/page_table_fifo_lru_replacement.sv -----
// Page table with FIFO or LRU replacement: control, tables and result register.
// A hit or a fault with a free frame passes from accept through S_LOOK, S_DONE, S_OUT.
// A fault in LRU mode with all frames used also scans the timestamp memory one page a
// cycle in S_SCAN before S_DONE; one word is in flight at a time, so no new word is
// taken until the FSM is back in S_IDLE, and a stalled result holds the next one back.
// Reset clears valid, dirty and frame-used bits, queue pointers and counters at
// once; there is no clearing pass. The mode register resets to FIFO.
module page_table_fifo_lru_replacement #(
    parameter int PAGE_COUNT = ptfl_pkg::NumPagesDef,
    parameter int NUM_FRAMES = ptfl_pkg::NumFramesDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_stall,
    input  ptfl_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output ptfl_pkg::t_out_word o_data
);

    localparam int PIdxW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int FIdxW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int PCntW = $clog2(PAGE_COUNT + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOOK = 5'b00010,
        S_SCAN = 5'b00100,
        S_DONE = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic                      r_mode;
    logic [PAGE_COUNT-1:0]     r_valid_pg;
    logic [PAGE_COUNT-1:0]     r_dirty_pg;
    logic [FIdxW-1:0]          r_frame_pg [PAGE_COUNT];
    logic [NUM_FRAMES-1:0]     r_used;
    logic [PIdxW-1:0]          r_queue [NUM_FRAMES];
    logic [FIdxW-1:0]          r_head, r_tail;
    logic [ptfl_pkg::CountW-1:0] r_hits, r_misses;

    ptfl_pkg::t_in_word        r_in;
    ptfl_pkg::t_out_word       r_out;
    ptfl_pkg::t_out_word       n_out;
    logic                      r_out_valid;

    logic [PCntW-1:0]          r_scan;
    logic [PIdxW-1:0]          r_best;
    logic [ptfl_pkg::TimeW-1:0] r_best_time;
    logic                      r_found;

    // Timestamp memory.
    logic                      tm_we;
    logic [PIdxW-1:0]          tm_waddr, tm_raddr;
    logic [ptfl_pkg::TimeW-1:0] tm_wdata, tm_rdata;

    ptfl_time_mem #(.NumPages(PAGE_COUNT)) u_time (
        .i_clk  (i_clk),
        .i_we   (tm_we),
        .i_waddr(tm_waddr),
        .i_wdata(tm_wdata),
        .i_raddr(tm_raddr),
        .o_rdata(tm_rdata)
    );

    logic               in_range;
    logic [PIdxW-1:0]   pg;
    logic               have_free;
    logic [FIdxW-1:0]   free_idx;
    logic [PIdxW-1:0]   scan_pg;
    logic [PIdxW-1:0]   prev_pg;
    logic               take_prev;
    logic [PIdxW-1:0]   victim;
    logic [FIdxW-1:0]   slot;
    logic [FIdxW-1:0]   head_nx;
    logic               out_free;

    assign pg       = r_in.page[PIdxW-1:0];
    assign in_range = ({28'd0, r_in.page} < 32'(PAGE_COUNT));
    assign scan_pg  = r_scan[PIdxW-1:0];
    assign prev_pg  = PIdxW'(r_scan - PCntW'(1));
    assign head_nx  = (r_head == FIdxW'(NUM_FRAMES - 1)) ? '0 : r_head + FIdxW'(1);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        have_free = 1'b0;
        free_idx  = '0;
        for (int f = NUM_FRAMES - 1; f >= 0; f--) begin
            if (!r_used[f]) begin
                have_free = 1'b1;
                free_idx  = FIdxW'(f);
            end
        end
    end

    // Data read last cycle belongs to page r_scan-1.
    assign take_prev = (r_scan != '0) && r_valid_pg[prev_pg] &&
                       (!r_found || tm_rdata < r_best_time);

    assign victim = (r_mode == ptfl_pkg::ModeLru) ? r_best : r_queue[r_head];

    always_comb begin
        slot = r_head;
        if (r_mode == ptfl_pkg::ModeLru) begin
            for (int s = NUM_FRAMES - 1; s >= 0; s--) begin
                if (r_queue[s] == victim) begin
                    slot = FIdxW'(s);
                end
            end
        end
    end

    assign tm_raddr = (r_state == S_SCAN) ? scan_pg : pg;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_LOOK;
            S_LOOK: begin
                if (in_range && !r_valid_pg[pg] && !have_free &&
                    r_mode == ptfl_pkg::ModeLru) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: if (r_scan == PCntW'(PAGE_COUNT)) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        tm_we    = 1'b0;
        tm_waddr = pg;
        tm_wdata = r_in.timestamp;
        if (r_state == S_DONE && in_range) begin
            tm_we = 1'b1;
        end
    end

    // Result word for the access held in r_in.
    always_comb begin
        n_out            = '0;
        n_out.hit_total  = r_hits;
        n_out.miss_total = r_misses;
        if (in_range) begin
            if (r_valid_pg[pg]) begin
                n_out.hit       = 1'b1;
                n_out.hit_total = r_hits + ptfl_pkg::CountW'(1);
                n_out.frame     = ptfl_pkg::FrameW'(r_frame_pg[pg]);
            end else begin
                n_out.miss_total = r_misses + ptfl_pkg::CountW'(1);
                if (have_free) begin
                    n_out.frame = ptfl_pkg::FrameW'(free_idx);
                end else begin
                    n_out.evicted     = 1'b1;
                    n_out.victim_page = ptfl_pkg::PageW'(victim);
                    n_out.write_back  = r_dirty_pg[victim];
                    n_out.frame       = ptfl_pkg::FrameW'(r_frame_pg[victim]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= ptfl_pkg::ModeFifo;
            r_valid_pg  <= '0;
            r_dirty_pg  <= '0;
            r_used      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
            r_scan      <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (r_state == S_OUT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_scan  <= '0;
                    r_found <= 1'b0;
                end
                S_LOOK: ;
                S_SCAN: begin
                    r_scan <= r_scan + PCntW'(1);
                    if (take_prev) begin
                        r_found <= 1'b1;
                    end
                end
                S_DONE: begin
                    // The tables change only once the previous word has left.
                    if (out_free) begin
                        r_out    <= n_out;
                        r_hits   <= n_out.hit_total;
                        r_misses <= n_out.miss_total;
                        if (in_range) begin
                            if (r_valid_pg[pg]) begin
                                if (r_in.wr_access) r_dirty_pg[pg] <= 1'b1;
                            end else begin
                                r_valid_pg[pg] <= 1'b1;
                                r_dirty_pg[pg] <= r_in.wr_access;
                                if (have_free) begin
                                    r_used[free_idx] <= 1'b1;
                                    r_frame_pg[pg]   <= free_idx;
                                    r_queue[r_tail]  <= pg;
                                    r_tail <= (r_tail == FIdxW'(NUM_FRAMES - 1)) ?
                                              '0 : r_tail + FIdxW'(1);
                                end else begin
                                    r_frame_pg[pg] <= r_frame_pg[victim];
                                    r_queue[slot]  <= pg;
                                    if (victim != pg) begin
                                        r_valid_pg[victim] <= 1'b0;
                                        r_dirty_pg[victim] <= 1'b0;
                                    end
                                    if (r_mode == ptfl_pkg::ModeFifo) begin
                                        r_head <= head_nx;
                                        r_tail <= head_nx;
                                    end
                                end
                            end
                        end
                    end
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    // Payload registers without reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_in <= i_data;
        end
        if (r_state == S_SCAN && take_prev) begin
            r_best      <= prev_pg;
            r_best_time <= tm_rdata;
        end
    end

    // Final result word is registered in S_DONE and released in S_OUT.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_state == S_OUT))
        else $error("done not followed by output");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_valid_pg[pg] && in_range && !have_free)
        |-> r_valid_pg[victim] || r_mode == ptfl_pkg::ModeFifo)
        else $error("LRU victim not resident");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan <= PCntW'(PAGE_COUNT)))
        else $error("scan overrun");

endmodule
